// File: hdl/tf4x32_pkg.sv
package tf4x32_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned NUM_KS    = NUM_WORDS + 1;
  localparam int unsigned ROUNDS    = 20;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] KS_PARITY = 32'h1BD1_1BDA;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 3'd3;

  typedef logic [WORD_W-1:0] word_t;

  function automatic int unsigned rot_amount(input int unsigned idx);
    int unsigned amt;
    case (idx % 16)
      0:       amt = 10;
      1:       amt = 26;
      2:       amt = 11;
      3:       amt = 21;
      4:       amt = 13;
      5:       amt = 27;
      6:       amt = 23;
      7:       amt = 5;
      8:       amt = 6;
      9:       amt = 20;
      10:      amt = 17;
      11:      amt = 11;
      12:      amt = 25;
      13:      amt = 10;
      14:      amt = 18;
      15:      amt = 20;
      default: amt = 0;
    endcase
    return amt;
  endfunction

  function automatic word_t rotl32(input word_t v, input int unsigned n);
    int unsigned sh;
    sh = n % 32;
    if (sh == 0) begin
      return v;
    end
    return (v << sh) | (v >> (WORD_W - sh));
  endfunction

endpackage

// File: hdl/threefry_4x32_20_generator_unit.sv
// Threefry-4x32-20 counter-mode generator, one pipeline stage per round.
// Each word is registered at stage 0 (key add) and then once per round; done_o flags the last.
// Throughput: one counter word set per cycle; busy_o is never raised.
// The receiver cannot stall: each result shows for one cycle with done_o.
// Reset (rst_ni low, asynchronous) clears the key registers and the stage valids.
module threefry_4x32_20_generator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  tf4x32_pkg::word_t                ctr_word0_i,
  input  tf4x32_pkg::word_t                ctr_word1_i,
  input  tf4x32_pkg::word_t                ctr_word2_i,
  input  tf4x32_pkg::word_t                ctr_word3_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tf4x32_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  tf4x32_pkg::word_t                cfg_data_i,
  output logic                             done_o,
  output tf4x32_pkg::word_t                rand_word0_o,
  output tf4x32_pkg::word_t                rand_word1_o,
  output tf4x32_pkg::word_t                rand_word2_o,
  output tf4x32_pkg::word_t                rand_word3_o
);
  import tf4x32_pkg::*;

  word_t key_q [NUM_WORDS];
  word_t ks    [NUM_KS];
  logic  accept;

  logic  valid_q [ROUNDS+1];
  word_t x_q     [ROUNDS+1][NUM_WORDS];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEY_WORD0: key_q[0] <= cfg_data_i;
        CFG_KEY_WORD1: key_q[1] <= cfg_data_i;
        CFG_KEY_WORD2: key_q[2] <= cfg_data_i;
        CFG_KEY_WORD3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      ks[i] = key_q[i];
    end
    ks[NUM_WORDS] = KS_PARITY ^ key_q[0] ^ key_q[1] ^ key_q[2] ^ key_q[3];
  end

  // stage 0: initial key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q[0][0] <= ctr_word0_i + ks[0];
      x_q[0][1] <= ctr_word1_i + ks[1];
      x_q[0][2] <= ctr_word2_i + ks[2];
      x_q[0][3] <= ctr_word3_i + ks[3];
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int unsigned RA  = rot_amount(2 * r);
    localparam int unsigned RB  = rot_amount(2 * r + 1);
    localparam bit          INJ = ((r + 1) % 4) == 0;
    localparam int unsigned S   = (r + 1) / 4;
    localparam int unsigned K0  = S % NUM_KS;
    localparam int unsigned K1  = (S + 1) % NUM_KS;
    localparam int unsigned K2  = (S + 2) % NUM_KS;
    localparam int unsigned K3  = (S + 3) % NUM_KS;

    word_t y [NUM_WORDS];

    always_comb begin
      if ((r % 2) == 0) begin
        y[0] = x_q[r][0] + x_q[r][1];
        y[1] = rotl32(x_q[r][1], RA) ^ y[0];
        y[2] = x_q[r][2] + x_q[r][3];
        y[3] = rotl32(x_q[r][3], RB) ^ y[2];
      end else begin
        y[0] = x_q[r][0] + x_q[r][3];
        y[3] = rotl32(x_q[r][3], RA) ^ y[0];
        y[2] = x_q[r][2] + x_q[r][1];
        y[1] = rotl32(x_q[r][1], RB) ^ y[2];
      end
      if (INJ) begin
        y[0] = y[0] + ks[K0];
        y[1] = y[1] + ks[K1];
        y[2] = y[2] + ks[K2];
        y[3] = y[3] + ks[K3] + WORD_W'(S);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[r+1] <= 1'b0;
      end else begin
        valid_q[r+1] <= valid_q[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (valid_q[r]) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          x_q[r+1][i] <= y[i];
        end
      end
    end
  end

  assign done_o       = valid_q[ROUNDS];
  assign rand_word0_o = x_q[ROUNDS][0];
  assign rand_word1_o = x_q[ROUNDS][1];
  assign rand_word2_o = x_q[ROUNDS][2];
  assign rand_word3_o = x_q[ROUNDS][3];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(ROUNDS + 1) done_o)
    else $error("word did not come out after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q[ROUNDS-1]))
    else $error("done without a word in the last round stage");

  a_key_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_KEY_WORD0)
      |=> key_q[0] == $past(cfg_data_i))
    else $error("key word 0 not updated by config write");

endmodule

// File: tb/tb.sv
module tb;
  import tf4x32_pkg::word_t;
  import tf4x32_pkg::CFG_IDX_W;
  import tf4x32_pkg::CFG_KEY_WORD0;
  import tf4x32_pkg::CFG_KEY_WORD1;
  import tf4x32_pkg::CFG_KEY_WORD2;
  import tf4x32_pkg::CFG_KEY_WORD3;

  typedef logic [3:0][31:0] block_t;

  localparam int unsigned ROUND_COUNT = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 160;

  class block_tracker;
    word_t  key [4];
    block_t expected_blocks [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < 4; i++) key[i] = '0;
      errors = 0;
    endfunction

    function void write_key(logic [CFG_IDX_W-1:0] idx, word_t data);
      if (idx <= CFG_KEY_WORD3) key[idx[1:0]] = data;
    endfunction

    static function word_t rot_left(word_t v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function block_t threefry_block(block_t ctr);
      int unsigned rot [16];
      word_t ks [5];
      block_t x;
      int unsigned a, b, n, s;
      rot = '{10, 26, 11, 21, 13, 27, 23, 5, 6, 20, 17, 11, 25, 10, 18, 20};
      ks[4] = 32'h1BD1_1BDA;
      for (int i = 0; i < 4; i++) begin
        ks[i] = key[i];
        ks[4] ^= key[i];
        x[i] = ctr[i] + key[i];
      end
      for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
        for (int unsigned p = 0; p < 2; p++) begin
          a = 2 * p;
          if (r % 2 == 0) b = 2 * p + 1;
          else b = 3 - 2 * p;
          n = rot[(2 * r + p) % 16];
          x[a] = x[a] + x[b];
          x[b] = rot_left(x[b], n) ^ x[a];
        end
        if ((r + 1) % 4 == 0) begin
          s = (r + 1) / 4;
          for (int unsigned i = 0; i < 4; i++) x[i] = x[i] + ks[(s + i) % 5];
          x[3] = x[3] + word_t'(s);
        end
      end
      return x;
    endfunction

    function void note_counter(block_t ctr);
      expected_blocks.push_back(threefry_block(ctr));
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: rand_word%0d expected %h got %h", $time, i, want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  word_t ctr_word0_i = '0;
  word_t ctr_word1_i = '0;
  word_t ctr_word2_i = '0;
  word_t ctr_word3_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  word_t cfg_data_i = '0;
  logic busy_o, cfg_ready_o, done_o;
  word_t rand_word0_o, rand_word1_o, rand_word2_o, rand_word3_o;

  int unsigned cycle_count = 0;
  block_tracker sb = new();

  threefry_4x32_20_generator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .ctr_word0_i  (ctr_word0_i),
    .ctr_word1_i  (ctr_word1_i),
    .ctr_word2_i  (ctr_word2_i),
    .ctr_word3_i  (ctr_word3_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .rand_word0_o (rand_word0_o),
    .rand_word1_o (rand_word1_o),
    .rand_word2_o (rand_word2_o),
    .rand_word3_o (rand_word3_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[threefry_4x32_20_generator_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_counter({ctr_word3_i, ctr_word2_i, ctr_word1_i, ctr_word0_i});
      if (cfg_valid_i && cfg_ready_o) sb.write_key(cfg_index_i, cfg_data_i);
      if (done_o)
        sb.check_block({rand_word3_o, rand_word2_o, rand_word1_o, rand_word0_o});
    end
  end

  // leaves cfg_valid_i high; caller lowers it after the last word
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_keys(input block_t k, input bit spare);
    write_cfg(CFG_KEY_WORD0, k[0]);
    write_cfg(CFG_KEY_WORD1, k[1]);
    write_cfg(CFG_KEY_WORD2, k[2]);
    write_cfg(CFG_KEY_WORD3, k[3]);
    if (spare) write_cfg(3'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // leaves start_i high; caller lowers it after the last word
  task automatic send_counter(input block_t ctr, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    ctr_word0_i <= ctr[0];
    ctr_word1_i <= ctr[1];
    ctr_word2_i <= ctr[2];
    ctr_word3_i <= ctr[3];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // waits on the clock first so the monitor has noted the last accepted word
  task automatic drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic block_t pick_block();
    return {pick_word(), pick_word(), pick_word(), pick_word()};
  endfunction

  task automatic random_phase(input int unsigned idle_pct);
    for (int n = 0; n < RANDOM_PER_PHASE; n++) send_counter(pick_block(), idle_pct);
    start_i <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key
    send_counter('0, 0);
    send_counter('1, 0);
    send_counter({32'd3, 32'd2, 32'd1, 32'd0}, 0);
    start_i <= 1'b0;
    drain();

    // all-ones key, spare index must be ignored
    write_keys('1, 1'b1);
    send_counter('0, 0);
    send_counter('1, 0);
    send_counter({4{32'hAAAA_AAAA}}, 0);
    send_counter({4{32'h5555_5555}}, 0);
    send_counter({32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001}, 0);
    start_i <= 1'b0;
    drain();

    write_keys({32'hA409_3822, 32'h299F_31D0, 32'h1319_8A2E, 32'h0370_7344}, 1'b0);
    send_counter({32'h243F_6A88, 32'h85A3_08D3, 32'h1319_8A2E, 32'h0370_7344}, 0);
    send_counter('0, 0);
    send_counter('1, 0);
    send_counter({32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0}, 0);
    for (int i = 0; i < 8; i++) send_counter(block_t'(128'd1 << (i * 17)), 0);
    start_i <= 1'b0;
    drain();

    write_keys(pick_block(), 1'b1);
    random_phase(34);
    write_keys({32'h0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF}, 1'b0);
    random_phase(71);
    write_keys({$urandom, $urandom, $urandom, $urandom}, 1'b1);
    random_phase(0);

    repeat (ROUND_COUNT + 5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[threefry_4x32_20_generator_unit] OK");
    end else begin
      $display("[threefry_4x32_20_generator_unit] ERROR");
    end
    $finish;
  end
endmodule
